@@ hdl/dvp_pkg.sv @@
`default_nettype none

package dvp_pkg;

    localparam int PART_COUNT = 4;
    localparam int PART_BITS = 16;
    localparam int PACKED_BITS = 48;
    localparam int VERSION_BITS = 64;

    localparam logic [PART_BITS-1:0] CH_DOT = 16'h002E;
    localparam logic [PART_BITS-1:0] CH_ZERO = 16'h0030;
    localparam logic [PART_BITS-1:0] CH_NINE = 16'h0039;

    localparam logic [1:0] LAST_PART = 2'(PART_COUNT - 1);

    typedef struct packed {
        logic [PART_BITS-1:0] code_unit;
        logic                 present;
        logic                 last;
    } dvp_in_t;

    typedef struct packed {
        logic                    ok;
        logic [VERSION_BITS-1:0] version;
    } dvp_out_t;

endpackage

`default_nettype wire

@@ hdl/dotted_version_parser.sv @@
`default_nettype none

// channel | signals                      | direction | accepted when
// input   | in_valid, in_ready, in_data  | into      | in_valid && in_ready
// output  | out_valid, out_ready, out_data| out of    | out_valid && out_ready
//
// one character per cycle while no last item is held back: an item sits in the input register, where the
// part logic (times ten, add, overflow compare) updates the parse state.
// an item marked last loads the result register as it leaves the input register.
// a stalled output only holds back an item marked last; other items keep flowing.
// reset clears the parse state and both valid flags.
module dotted_version_parser
    import dvp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dvp_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output dvp_out_t      out_data
);

    logic                   stage_valid_reg;
    dvp_in_t                stage_item_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    dvp_out_t               out_item_reg;

    logic [1:0]             part_index_reg, part_index_next;
    logic [PART_BITS-1:0]   part_value_reg, part_value_next;
    logic [PACKED_BITS-1:0] packed_parts_reg, packed_parts_next;
    logic                   seen_digit_reg, seen_digit_next;
    logic                   failed_reg, failed_next;

    logic                   fire;
    logic                   is_digit;
    logic                   is_dot;
    logic [PART_BITS+3:0]   scaled;
    logic                   done_ok;
    dvp_out_t               result;

    // only a last item needs room in the result register
    assign fire = stage_valid_reg
        && (!stage_item_reg.last || !out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || fire;

    assign is_digit = stage_item_reg.code_unit >= CH_ZERO
        && stage_item_reg.code_unit <= CH_NINE;
    assign is_dot = stage_item_reg.code_unit == CH_DOT;

    // value * 10 + digit, as (v << 3) + (v << 1) + d
    assign scaled = {1'b0, part_value_reg, 3'b000}
        + {3'b000, part_value_reg, 1'b0}
        + {16'h0000, stage_item_reg.code_unit[3:0]};

    always_comb
    begin
        part_index_next = part_index_reg;
        part_value_next = part_value_reg;
        packed_parts_next = packed_parts_reg;
        seen_digit_next = seen_digit_reg;
        failed_next = failed_reg;
        if (stage_item_reg.present && !failed_reg)
        begin
            if (is_digit)
            begin
                if (scaled[PART_BITS+3:PART_BITS] != 4'h0)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    part_value_next = scaled[PART_BITS-1:0];
                    seen_digit_next = 1'b1;
                end
            end
            else if (is_dot)
            begin
                if (!seen_digit_reg || part_index_reg >= LAST_PART)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    packed_parts_next = {packed_parts_reg[PACKED_BITS-PART_BITS-1:0],
                        part_value_reg};
                    part_index_next = part_index_reg + 2'd1;
                    part_value_next = '0;
                    seen_digit_next = 1'b0;
                end
            end
            else
            begin
                failed_next = 1'b1;
            end
        end
    end

    assign done_ok = !failed_next && seen_digit_next && part_index_next == LAST_PART;
    assign result.ok = done_ok;
    assign result.version = done_ok ? {packed_parts_next, part_value_next} : '0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire && stage_item_reg.last)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            part_index_reg <= '0;
            part_value_reg <= '0;
            packed_parts_reg <= '0;
            seen_digit_reg <= 1'b0;
            failed_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (fire)
            begin
                if (stage_item_reg.last)
                begin
                    part_index_reg <= '0;
                    part_value_reg <= '0;
                    packed_parts_reg <= '0;
                    seen_digit_reg <= 1'b0;
                    failed_reg <= 1'b0;
                end
                else
                begin
                    part_index_reg <= part_index_next;
                    part_value_reg <= part_value_next;
                    packed_parts_reg <= packed_parts_next;
                    seen_digit_reg <= seen_digit_next;
                    failed_reg <= failed_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_item_reg <= in_data;
        end
        if (fire && stage_item_reg.last)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_item_reg;

endmodule

`default_nettype wire

@@ tb/tb_dotted_version_parser.sv @@
`timescale 1ns / 1ps

module tb_dotted_version_parser;
    import dvp_pkg::*;

    class version_scoreboard;
        logic [1:0]             part_idx;
        logic [PART_BITS-1:0]   part_val;
        logic [PACKED_BITS-1:0] done_parts;
        bit                     seen_digit;
        bit                     rejected;
        dvp_out_t               expected_versions[$];
        int                     mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            part_idx = '0;
            part_val = '0;
            done_parts = '0;
            seen_digit = 0;
            rejected = 0;
        endfunction

        function int pending();
            return expected_versions.size();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        // parse one accepted item; an item marked last yields one expected result
        function void note_item(dvp_in_t item);
            int unsigned next_val;
            dvp_out_t    res;
            if (item.present && !rejected)
            begin
                if (item.code_unit >= CH_ZERO && item.code_unit <= CH_NINE)
                begin
                    next_val = int'(part_val) * 10 + int'(item.code_unit - CH_ZERO);
                    if (next_val > 32'h0000_FFFF)
                        rejected = 1;
                    else
                    begin
                        part_val = next_val[15:0];
                        seen_digit = 1;
                    end
                end
                else if (item.code_unit == CH_DOT)
                begin
                    if (!seen_digit || part_idx >= LAST_PART)
                        rejected = 1;
                    else
                    begin
                        done_parts = {done_parts[PACKED_BITS-PART_BITS-1:0], part_val};
                        part_idx = part_idx + 2'd1;
                        part_val = '0;
                        seen_digit = 0;
                    end
                end
                else
                    rejected = 1;
            end
            if (item.last)
            begin
                res.ok = !rejected && seen_digit && part_idx == LAST_PART;
                res.version = res.ok ? {done_parts, part_val} : '0;
                expected_versions.push_back(res);
                clear();
            end
        endfunction

        function void check_result(dvp_out_t got);
            dvp_out_t want;
            if (expected_versions.size() == 0)
            begin
                report($sformatf("unexpected result ok %0b version %h",
                                 got.ok, got.version));
                return;
            end
            want = expected_versions.pop_front();
            if (got.ok !== want.ok)
                report($sformatf("ok expected %0b actual %0b", want.ok, got.ok));
            if (got.version !== want.version)
                report($sformatf("version expected %h actual %h", want.version, got.version));
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    dvp_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    dvp_out_t out_data;

    version_scoreboard sb = new();
    dvp_in_t           chars[$];
    bit                send_idle;
    bit                drain_idle;
    int                sent_count;

    dotted_version_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // receiver side: random stall bursts while enabled
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (drain_idle && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // returns right after the accepting edge; the next call moves valid on the falling edge
    task automatic send_item(input dvp_in_t item);
        @(negedge clk);
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        sb.note_item(item);
        if (item.present || item.last)
            sent_count++;
    endtask

    task automatic hold_input();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic void add_char(logic [15:0] code);
        chars.push_back('{code_unit: code, present: 1'b1, last: 1'b0});
    endfunction

    function automatic void add_absent();
        chars.push_back('{code_unit: 16'($urandom_range(0, 65535)), present: 1'b0,
                          last: 1'b0});
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_char({8'h00, s[i]});
    endfunction

    // send the queued string; the end is either its final char or an empty item
    task automatic send_chars(input bit absent_end);
        if (chars.size() == 0)
            absent_end = 1;
        if (absent_end)
        begin
            add_absent();
            chars[$].last = 1'b1;
        end
        else
            chars[$].last = 1'b1;
        foreach (chars[i])
            send_item(chars[i]);
        chars.delete();
    endtask

    function automatic void build_version(int n_parts, bit allow_big);
        int    v;
        string s;
        for (int p = 0; p < n_parts; p++)
        begin
            case ($urandom_range(0, 5))
                0: v = 0;
                1: v = 65535;
                2: v = $urandom_range(0, 9);
                3: v = $urandom_range(0, 999);
                default: v = $urandom_range(0, 65535);
            endcase
            if (allow_big && $urandom_range(0, 3) == 0)
                v = $urandom_range(65536, 999999);
            s = $sformatf("%0d", v);
            if ($urandom_range(0, 7) == 0)
                s = {"00", s};
            if (p > 0)
                add_char(CH_DOT);
            add_text(s);
        end
    endfunction

    function automatic logic [15:0] odd_code();
        case ($urandom_range(0, 3))
            0: return 16'h002F;
            1: return 16'h003A;
            2: return {8'($urandom_range(1, 255)), 8'h30 + 8'($urandom_range(0, 9))};
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void corrupt_chars();
        int idx;
        if (chars.size() == 0)
            return;
        idx = $urandom_range(0, chars.size() - 1);
        case ($urandom_range(0, 4))
            1: chars[idx].code_unit = odd_code();
            2: chars.delete(idx);
            3: chars.insert(idx, '{code_unit: CH_DOT, present: 1'b1, last: 1'b0});
            4: add_char(CH_DOT);
            default: ;
        endcase
    endfunction

    initial
    begin
        int kind;
        in_valid = 1'b0;
        in_data = '0;
        rst_n = 1'b0;
        send_idle = 0;
        drain_idle = 0;
        sent_count = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty string, empty part, too few parts, other char at all ones
        send_chars(1);
        add_text(".");
        send_chars(0);
        add_text("7");
        send_chars(0);
        add_char(16'hFFFF);
        send_chars(0);
        // valid with an empty item inside and leading zeros
        add_text("1.2");
        add_absent();
        add_text(".3.007");
        send_chars(0);
        // overflow, then a digit after the rejection
        add_text("700009");
        send_chars(0);
        // too many parts
        add_text("1.2.3.4.");
        send_chars(0);

        hold_input();

        sent_count = 0;
        send_idle = 1;
        drain_idle = 1;
        while (sent_count < 700)
        begin
            if (sent_count > 600)
            begin
                send_idle = 0;
                drain_idle = 0;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                send_idle = 1'($urandom_range(0, 1));
                drain_idle = 1'($urandom_range(0, 1));
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5)
                build_version(PART_COUNT, 0);
            else if (kind <= 8)
            begin
                build_version($urandom_range(1, 5), 1);
                corrupt_chars();
            end
            else
                repeat ($urandom_range(0, 6))
                begin
                    case ($urandom_range(0, 2))
                        0: add_char(CH_ZERO + 16'($urandom_range(0, 9)));
                        1: add_char(CH_DOT);
                        default: add_char(odd_code());
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        chars[$].present = 1'b0;
                end
            if (chars.size() != 0 && $urandom_range(0, 5) == 0)
                chars.insert($urandom_range(0, chars.size()),
                             '{code_unit: 16'($urandom_range(0, 65535)), present: 1'b0,
                               last: 1'b0});
            send_chars($urandom_range(0, 4) == 0);
        end

        hold_input();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
